>>> rtl/core/integer_matrix_multiply_top_defines.svh
// ---------------------------------------------------------------------------
// integer matrix multiply assertion macros
// shared concurrent assertion helpers for the matrix multiply core
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define IMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property that also covers cycles in reset
`define IMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/imm_pkg.sv
// ---------------------------------------------------------------------------
// imm_pkg
// shared constants, types and helpers of the integer matrix multiply core
// ---------------------------------------------------------------------------
package imm_pkg;

  // largest matrix dimension and accumulator width
  localparam int MAX_DIM     = 8;
  localparam int DATA_WIDTH  = 32;

  // fixed field widths of the stream payloads
  localparam int ELEM_W      = 32;
  localparam int ROW_W       = 3;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_PAD_W   = 2;
  localparam int OUT_TDATA_W = ELEM_W + 2 * ROW_W + OUT_PAD_W;

  // element stores
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = ADDR_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_SECOND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_SECOND = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              rd_first;
    logic              rd_last;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              out_load;
    logic              out_err;
    logic              out_last;
    logic [ROW_W-1:0]  out_row;
    logic [ROW_W-1:0]  out_col;
  } imm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } imm_sts_t;

  // clamp a dimension register into 1..MAX_DIM
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = CFG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/integer_matrix_multiply_top.sv
// ---------------------------------------------------------------------------
// integer_matrix_multiply_top
// signed integer matrix multiplier with streaming element input and output
// ---------------------------------------------------------------------------
// Elements of A and then of B enter row by row, one per cycle while loading.
// After the last element of B the input stalls while one multiply-accumulate
// unit, fed by one read port on each element store, walks the product: each
// product element is summed one term a cycle through the read, multiply and
// accumulate registers and then loaded into the output register, later if the
// output is held off. A dimension mismatch gives a single flagged result
// after the last element. Dimension registers read 0 as 1 and anything above
// 8 as 8; sums wrap to 32 bits.
module integer_matrix_multiply_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]           cfg_data_i,
  // element input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [imm_pkg::ELEM_W-1:0]          s_axis_tdata,  // element[31:0]
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // product[31:0], out_row[34:32], out_col[37:35], zero pad[39:38]
  output logic [imm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,  // bad_dims[0]
  output logic                                m_axis_tlast
);
  import imm_pkg::*;

  imm_cmd_t cmd;
  imm_sts_t sts;

  // sequencer and configuration
  imm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // stores, multiply-accumulate and output register
  imm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> rtl/core/imm_ram.sv
// ---------------------------------------------------------------------------
// imm_ram
// simple dual-port RAM, one write port and one registered read port
// ---------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/imm_dp.sv
// ---------------------------------------------------------------------------
// imm_dp
// element stores, multiply-accumulate pipeline and output register
// ---------------------------------------------------------------------------
module imm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [imm_pkg::ELEM_W-1:0]          elem_i,
  input  imm_pkg::imm_cmd_t                   cmd_i,
  output imm_pkg::imm_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [imm_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic                                out_err_o,
  output logic                                out_last_o
);
  import imm_pkg::*;

  logic [ELEM_W-1:0]            a_rdata;
  logic [ELEM_W-1:0]            b_rdata;
  logic                         v1_q, first1_q, last1_q;
  logic                         v2_q, first2_q, last2_q;
  logic signed [DATA_WIDTH-1:0] a_ext, b_ext;
  logic signed [DATA_WIDTH-1:0] mult_d, mult_q;
  logic signed [DATA_WIDTH-1:0] acc_d, acc_q;
  logic                         done_q;
  logic                         out_valid_q;
  logic [ELEM_W-1:0]            out_prod_q;
  logic [ROW_W-1:0]             out_row_q, out_col_q;
  logic                         out_err_q, out_last_q;

  // first matrix store
  imm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (elem_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.a_addr),
    .rdata_o (a_rdata)
  );

  // second matrix store
  imm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (elem_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.b_addr),
    .rdata_o (b_rdata)
  );

  // term flags follow the read data through the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v1_q     <= cmd_i.rd_en;
      first1_q <= cmd_i.rd_first;
      last1_q  <= cmd_i.rd_last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= v2_q && last2_q;
    end
  end

  // multiply stage, product wraps to the accumulator width
  assign a_ext  = DATA_WIDTH'(signed'(a_rdata));
  assign b_ext  = DATA_WIDTH'(signed'(b_rdata));
  assign mult_d = a_ext * b_ext;

  // accumulate stage, restarts on the first term of a dot product
  assign acc_d = first2_q ? mult_q : acc_q + mult_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      mult_q <= mult_d;
    end
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload, sum taken at its own width, zero on an error result
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_prod_q <= cmd_i.out_err ? '0 : ELEM_W'(acc_q);
      out_row_q  <= cmd_i.out_row;
      out_col_q  <= cmd_i.out_col;
      out_err_q  <= cmd_i.out_err;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.acc_done = done_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {OUT_PAD_W'(0), out_col_q, out_row_q, out_prod_q};
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/core/imm_ctrl.sv
// ---------------------------------------------------------------------------
// imm_ctrl
// configuration registers, load counters and multiply sequencer
// ---------------------------------------------------------------------------
`include "integer_matrix_multiply_top_defines.svh"

module imm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output imm_pkg::imm_cmd_t             cmd_o,
  input  imm_pkg::imm_sts_t             sts_i
);
  import imm_pkg::*;

  localparam int         ST_W     = 3;
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [ST_W-1:0]   state_q, state_d;
  logic [CFG_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic              load_b_q, load_b_d;
  logic [ROW_W-1:0]  row_q, row_d, col_q, col_d, term_q, term_d;
  logic [ADDR_W-1:0] a_base_q, a_base_d, a_ptr_q, a_ptr_d, b_ptr_q, b_ptr_d;

  logic [CFG_W-1:0]  ra, ca, rb, cb;
  logic [CNT_W-1:0]  need_a, need_b, cnt_inc;
  logic              accept, reached, term_last, row_last, col_last;

  // configuration writes, taken only while loading so a walk keeps its sizes
  assign cfg_ready_o = (state_q == ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CFG_W'(1);
      cols_a_q <= CFG_W'(1);
      rows_b_q <= CFG_W'(1);
      cols_b_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROWS_FIRST:  rows_a_q <= cfg_data_i;
        REG_COLS_FIRST:  cols_a_q <= cfg_data_i;
        REG_ROWS_SECOND: rows_b_q <= cfg_data_i;
        REG_COLS_SECOND: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped dimensions and element counts
  assign ra        = eff_dim(rows_a_q);
  assign ca        = eff_dim(cols_a_q);
  assign rb        = eff_dim(rows_b_q);
  assign cb        = eff_dim(cols_b_q);
  assign need_a    = CNT_W'(ra) * CNT_W'(ca);
  assign need_b    = CNT_W'(rb) * CNT_W'(cb);
  assign cnt_inc   = load_cnt_q + CNT_W'(1);
  assign reached   = cnt_inc >= (load_b_q ? need_b : need_a);
  assign term_last = (CFG_W'(term_q) + CFG_W'(1)) == ca;
  assign row_last  = (CFG_W'(row_q) + CFG_W'(1)) == ra;
  assign col_last  = (CFG_W'(col_q) + CFG_W'(1)) == cb;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    load_b_d   = load_b_q;
    row_d      = row_q;
    col_d      = col_q;
    term_d     = term_q;
    a_base_d   = a_base_q;
    a_ptr_d    = a_ptr_q;
    b_ptr_d    = b_ptr_q;

    cmd_o          = '0;
    cmd_o.wr_addr  = load_cnt_q[ADDR_W-1:0];
    cmd_o.a_addr   = a_ptr_q;
    cmd_o.b_addr   = b_ptr_q;
    cmd_o.rd_first = (term_q == '0);
    cmd_o.rd_last  = term_last;
    cmd_o.out_row  = row_q;
    cmd_o.out_col  = col_q;
    cmd_o.out_last = row_last && col_last;

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          cmd_o.wr_a = !load_b_q;
          cmd_o.wr_b = load_b_q;
          load_cnt_d = reached ? '0 : cnt_inc;
          if (reached) begin
            load_b_d = !load_b_q;
            if (load_b_q) begin
              row_d    = '0;
              col_d    = '0;
              term_d   = '0;
              a_base_d = '0;
              a_ptr_d  = '0;
              b_ptr_d  = '0;
              state_d  = (ca != rb) ? ST_ERR : ST_MAC;
            end
          end
        end
      end
      ST_MAC: begin
        // one dot product term per cycle
        cmd_o.rd_en = 1'b1;
        a_ptr_d     = a_ptr_q + ADDR_W'(1);
        b_ptr_d     = b_ptr_q + ADDR_W'(cb);
        term_d      = term_q + ROW_W'(1);
        if (term_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.acc_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          term_d         = '0;
          if (col_last) begin
            col_d    = '0;
            row_d    = row_q + ROW_W'(1);
            a_base_d = a_base_q + ADDR_W'(ca);
            a_ptr_d  = a_base_q + ADDR_W'(ca);
            b_ptr_d  = '0;
            state_d  = row_last ? ST_LOAD : ST_MAC;
          end else begin
            col_d   = col_q + ROW_W'(1);
            a_ptr_d = a_base_q;
            b_ptr_d = ADDR_W'(col_q) + ADDR_W'(1);
            state_d = ST_MAC;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_row  = '0;
          cmd_o.out_col  = '0;
          state_d        = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      load_b_q   <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      term_q     <= '0;
      a_base_q   <= '0;
      a_ptr_q    <= '0;
      b_ptr_q    <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      load_b_q   <= load_b_d;
      row_q      <= row_d;
      col_q      <= col_d;
      term_q     <= term_d;
      a_base_q   <= a_base_d;
      a_ptr_q    <= a_ptr_d;
      b_ptr_q    <= b_ptr_d;
    end
  end

  // checks
  `IMM_ASSERT(a_done_in_drain, sts_i.acc_done |-> state_q == ST_DRAIN, "sum finished outside drain")
  `IMM_ASSERT(a_load_when_free, cmd_o.out_load |-> sts_i.out_free, "output register overwritten")
  `IMM_ASSERT(a_cnt_in_range, load_cnt_q < CNT_W'(STORE_DEPTH), "load count past store depth")
  `IMM_ASSERT(a_mismatch_err, accept && load_b_q && reached && (ca != rb) |=> state_q == ST_ERR, "mismatch not flagged")
  `IMM_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> state_q == ST_LOAD, "not loading after reset")

endmodule
